/* rtl/hsec_pkg.sv */
// Shared types, constants and helper functions of the Hamming single-error coder.
`default_nettype none

package hsec_pkg;

	localparam int MSG_BITS  = 57;
	localparam int CODE_BITS = 64;
	localparam int SYN_BITS  = 7;
	localparam int LEN_BITS  = 6;

	localparam logic [LEN_BITS-1:0] MSG_MIN     = 6'd1;
	localparam logic [LEN_BITS-1:0] MSG_MAX     = 6'd57;
	localparam logic [LEN_BITS-1:0] LEN_K_RESET = 6'd4;
	localparam logic [LEN_BITS-1:0] LEN_N_RESET = 6'd7;

	typedef enum logic [0:0] {
		CMD_ENCODE  = 1'b0,
		CMD_CORRECT = 1'b1
	} cmd_t;

	// Message length in use and the codeword length that goes with it.
	typedef struct packed {
		logic [LEN_BITS-1:0] k;
		logic [LEN_BITS-1:0] n;
	} len_cfg_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] codeword;
		logic [MSG_BITS-1:0]  message;
		logic [SYN_BITS-1:0]  err_pos;
		logic                 unc;
	} result_t;

	function automatic logic is_pow2(input int p);
		return (p != 0) && ((p & (p - 1)) == 0);
	endfunction

	// Bit b is set when position b+1 has syndrome bit i set.
	function automatic logic [CODE_BITS-1:0] syn_mask(input int i);
		logic [CODE_BITS-1:0] m;
		m = '0;
		for (int b = 0; b < CODE_BITS; b++) begin
			m[b] = 1'(((b + 1) >> i) & 1);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

/* rtl/hsec_ifs.sv */
// Channel interfaces: request, response and configuration write.
`default_nettype none

interface hsec_req_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [hsec_pkg::MSG_BITS-1:0]  message_in;
	logic [hsec_pkg::CODE_BITS-1:0] received_word;

	modport source (output valid, output cmd, output message_in, output received_word,
		input ready);
	modport sink (input valid, input cmd, input message_in, input received_word,
		output ready);
endinterface

interface hsec_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [hsec_pkg::CODE_BITS-1:0] codeword_out;
	logic [hsec_pkg::MSG_BITS-1:0]  message_out;
	logic [hsec_pkg::SYN_BITS-1:0]  error_position;
	logic                           uncorrectable;

	modport source (output valid, output codeword_out, output message_out,
		output error_position, output uncorrectable, input ready);
	modport sink (input valid, input codeword_out, input message_out,
		input error_position, input uncorrectable, output ready);
endinterface

interface hsec_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [hsec_pkg::LEN_BITS-1:0] message_length;

	modport source (output valid, output message_length, input ready);
	modport sink (input valid, input message_length, output ready);
endinterface

`default_nettype wire

/* rtl/hsec_cfg.sv */
// Message length register with saturation and codeword length derivation.
`default_nettype none

module hsec_cfg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	hsec_cfg_if.sink            cfg,
	output hsec_pkg::len_cfg_t  len
);

	logic [hsec_pkg::LEN_BITS-1:0] k_sat;
	logic [hsec_pkg::LEN_BITS-1:0] r_cnt;
	logic [hsec_pkg::LEN_BITS-1:0] k_q;
	logic [hsec_pkg::LEN_BITS-1:0] n_q;

	assign cfg.ready = 1'b1;

	// Parity count is the least r with 2^r >= k + r + 1.
	always_comb begin
		if (cfg.message_length < hsec_pkg::MSG_MIN) begin
			k_sat = hsec_pkg::MSG_MIN;
		end else if (cfg.message_length > hsec_pkg::MSG_MAX) begin
			k_sat = hsec_pkg::MSG_MAX;
		end else begin
			k_sat = cfg.message_length;
		end
		if (k_sat <= 6'd1) begin
			r_cnt = 6'd2;
		end else if (k_sat <= 6'd4) begin
			r_cnt = 6'd3;
		end else if (k_sat <= 6'd11) begin
			r_cnt = 6'd4;
		end else if (k_sat <= 6'd26) begin
			r_cnt = 6'd5;
		end else begin
			r_cnt = 6'd6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= hsec_pkg::LEN_K_RESET;
			n_q <= hsec_pkg::LEN_N_RESET;
		end else if (cfg.valid && cfg.ready) begin
			k_q <= k_sat;
			n_q <= k_sat + r_cnt;
		end
	end

	assign len.k = k_q;
	assign len.n = n_q;

endmodule

`default_nettype wire

/* rtl/hsec_core.sv */
// Combinational encode and check-and-correct logic for one registered item.
`default_nettype none

module hsec_core (
	input  wire logic                           cmd,
	input  wire logic [hsec_pkg::MSG_BITS-1:0]  msg,
	input  wire logic [hsec_pkg::CODE_BITS-1:0] rx,
	input  wire hsec_pkg::len_cfg_t             len,
	output hsec_pkg::result_t                   res
);

	logic [hsec_pkg::MSG_BITS-1:0]  msg_m;
	logic [hsec_pkg::CODE_BITS-1:0] code_mask;
	logic [hsec_pkg::CODE_BITS-1:0] data_w;
	logic [hsec_pkg::CODE_BITS-1:0] enc_w;
	logic [hsec_pkg::CODE_BITS-1:0] rx_m;
	logic [hsec_pkg::CODE_BITS-1:0] flip;
	logic [hsec_pkg::CODE_BITS-1:0] dec_w;
	logic [hsec_pkg::MSG_BITS-1:0]  dec_msg;
	logic [hsec_pkg::SYN_BITS-1:0]  syn_e;
	logic [hsec_pkg::SYN_BITS-1:0]  syn_d;
	logic                           unc;

	always_comb begin
		for (int j = 0; j < hsec_pkg::MSG_BITS; j++) begin
			msg_m[j] = msg[j] & (j < int'(len.k));
		end
		for (int b = 0; b < hsec_pkg::CODE_BITS; b++) begin
			code_mask[b] = (b < int'(len.n));
		end
	end

	// Message bits fill the non-power-of-two positions in order. With k bits in
	// use they land exactly in positions 1..n, so no further masking is needed.
	always_comb begin
		int j;
		j = 0;
		data_w = '0;
		for (int p = 1; p < hsec_pkg::CODE_BITS; p++) begin
			if (!hsec_pkg::is_pow2(p)) begin
				if (j < hsec_pkg::MSG_BITS) begin
					data_w[p-1] = msg_m[j];
				end
				j++;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < hsec_pkg::SYN_BITS; i++) begin
			syn_e[i] = ^(data_w & hsec_pkg::syn_mask(i));
			syn_d[i] = ^(rx_m & hsec_pkg::syn_mask(i));
		end
	end

	assign rx_m = rx & code_mask;

	// Parity bit at position 2^i takes syndrome bit i of the data-only word.
	always_comb begin
		enc_w = data_w;
		for (int i = 0; i < hsec_pkg::SYN_BITS; i++) begin
			enc_w[(1 << i) - 1] = syn_e[i];
		end
	end

	assign unc = (syn_d > {1'b0, len.n});

	always_comb begin
		for (int b = 0; b < hsec_pkg::CODE_BITS; b++) begin
			flip[b] = !unc && (syn_d == hsec_pkg::SYN_BITS'(b + 1));
		end
	end

	assign dec_w = rx_m ^ flip;

	always_comb begin
		int j;
		j = 0;
		dec_msg = '0;
		for (int p = 1; p < hsec_pkg::CODE_BITS; p++) begin
			if (!hsec_pkg::is_pow2(p)) begin
				if (j < hsec_pkg::MSG_BITS) begin
					dec_msg[j] = dec_w[p-1];
				end
				j++;
			end
		end
	end

	always_comb begin
		if (cmd == hsec_pkg::CMD_CORRECT) begin
			res.codeword = dec_w;
			res.message  = dec_msg;
			res.err_pos  = syn_d;
			res.unc      = unc;
		end else begin
			res.codeword = enc_w;
			res.message  = msg_m;
			res.err_pos  = '0;
			res.unc      = 1'b0;
		end
	end

endmodule

`default_nettype wire

/* rtl/hamming_sec_encode_correct_top.sv */
// Top level of the Hamming single-error-correcting encoder and corrector.
//
//   channel  dir  payload                                           transfer
//   req      in   cmd, message_in, received_word                    valid & ready
//   rsp      out  codeword_out, message_out, error_position,        valid & ready
//                 uncorrectable
//   cfg      in   message_length                                    valid & ready
//
// One item per cycle sustained while rsp.ready stays high; a result passes through the input
// register and the result register around the coder logic before it is presented.
// Reset clears the valid bits and loads a message length of four.
// A stalled response holds its data; requests keep flowing until both registers are full.
// The configuration channel is always ready.
`default_nettype none

module hamming_sec_encode_correct_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hsec_req_if.sink   req,
	hsec_rsp_if.source rsp,
	hsec_cfg_if.sink   cfg
);

	hsec_pkg::len_cfg_t len;
	hsec_pkg::result_t  res;

	logic                           vld_s1;
	logic                           cmd_s1;
	logic [hsec_pkg::MSG_BITS-1:0]  msg_s1;
	logic [hsec_pkg::CODE_BITS-1:0] rx_s1;
	logic                           vld_s2;
	hsec_pkg::result_t              res_s2;
	logic                           adv_s2;
	logic                           load_s1;

	hsec_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.len    (len)
	);

	hsec_core u_core (
		.cmd (cmd_s1),
		.msg (msg_s1),
		.rx  (rx_s1),
		.len (len),
		.res (res)
	);

	assign adv_s2    = !vld_s2 || rsp.ready;
	assign req.ready = !vld_s1 || adv_s2;
	assign load_s1   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= load_s1 || (vld_s1 && !adv_s2);
			vld_s2 <= (vld_s1 && adv_s2) || (vld_s2 && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1 <= req.cmd;
			msg_s1 <= req.message_in;
			rx_s1  <= req.received_word;
		end
		if (vld_s1 && adv_s2) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid          = vld_s2;
	assign rsp.codeword_out   = res_s2.codeword;
	assign rsp.message_out    = res_s2.message;
	assign rsp.error_position = res_s2.err_pos;
	assign rsp.uncorrectable  = res_s2.unc;

endmodule

`default_nettype wire

/* rtl/hsec_chk.sv */
// Port-level checker for the Hamming coder top level, with its bind statement.
`default_nettype none

module hsec_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           req_valid,
	input wire logic                           req_ready,
	input wire logic                           rsp_valid,
	input wire logic                           rsp_ready,
	input wire logic [hsec_pkg::CODE_BITS-1:0] rsp_codeword,
	input wire logic [hsec_pkg::SYN_BITS-1:0]  rsp_err_pos,
	input wire logic                           rsp_unc
);

	// A stalled response keeps its codeword.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_codeword))
		else $error("response changed while stalled");

	// An uncorrectable flag always comes with a nonzero syndrome.
	a_unc_syn: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_unc |-> rsp_err_pos != '0)
		else $error("uncorrectable flagged with zero syndrome");

	// With the response register empty, a request is always taken.
	a_req_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with empty response register");

	// An accepted item passes the input and result registers and reaches the response port when not stalled.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
		else $error("result missing after transfer");

endmodule

bind hamming_sec_encode_correct_top hsec_chk u_hsec_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_codeword (rsp.codeword_out),
	.rsp_err_pos  (rsp.error_position),
	.rsp_unc      (rsp.uncorrectable)
);

`default_nettype wire

/* tb/hamming_sec_encode_correct_top_tb.sv */
// Self-checking testbench of the Hamming single-error encoder and corrector, with a scoreboard.
`default_nettype none

module hamming_sec_encode_correct_top_tb;

	localparam int CYCLE_LIMIT = 400000;

	// Holds the coder's length setting and the responses still to come, and
	// works out what each request must produce.
	class coder_scoreboard;
		logic [hsec_pkg::LEN_BITS-1:0] length_reg;
		int                            k_used;
		int                            n_used;
		hsec_pkg::result_t             awaited_results[$];
		int                            mismatches;
		int                            encodes;
		int                            corrections;
		int                            flagged;
		int                            settings;

		function new();
			length_reg = hsec_pkg::LEN_K_RESET;
			resolve_length();
		endfunction

		function int parity_bits(int k);
			int r;
			r = 0;
			while (r < hsec_pkg::SYN_BITS && (1 << r) < k + r + 1)
				r++;
			return r;
		endfunction

		// Clamps the register value to a usable message length and derives n.
		function void resolve_length();
			int r;
			k_used = length_reg;
			if (k_used < 1)
				k_used = 1;
			if (k_used > hsec_pkg::MSG_BITS)
				k_used = hsec_pkg::MSG_BITS;
			r = parity_bits(k_used);
			while (k_used > 1 && k_used + r > hsec_pkg::CODE_BITS) begin
				k_used--;
				r = parity_bits(k_used);
			end
			n_used = k_used + r;
		endfunction

		function void set_length(logic [hsec_pkg::LEN_BITS-1:0] value);
			length_reg = value;
			resolve_length();
			settings++;
		endfunction

		function int syndrome(logic [hsec_pkg::CODE_BITS-1:0] word);
			int s;
			s = 0;
			for (int p = 1; p <= n_used; p++)
				if (word[p-1])
					s ^= p;
			return s;
		endfunction

		function logic [hsec_pkg::MSG_BITS-1:0] data_bits(
			logic [hsec_pkg::CODE_BITS-1:0] word);
			logic [hsec_pkg::MSG_BITS-1:0] m;
			int                            j;
			m = '0;
			j = 0;
			for (int p = 1; p <= n_used; p++) begin
				if ((p & (p - 1)) != 0) begin
					m[j] = word[p-1];
					j++;
				end
			end
			return m;
		endfunction

		// Message bits at k and above never land in the word since only k data slots exist.
		function logic [hsec_pkg::CODE_BITS-1:0] encode(logic [hsec_pkg::MSG_BITS-1:0] msg);
			logic [hsec_pkg::CODE_BITS-1:0] word;
			int                             j;
			int                             s;
			word = '0;
			j = 0;
			for (int p = 1; p <= n_used; p++) begin
				if ((p & (p - 1)) != 0) begin
					word[p-1] = msg[j];
					j++;
				end
			end
			s = syndrome(word);
			for (int p = 1; p <= n_used; p = p * 2)
				if ((s & p) != 0)
					word[p-1] = 1'b1;
			return word;
		endfunction

		function hsec_pkg::result_t predict(hsec_pkg::cmd_t op,
			logic [hsec_pkg::MSG_BITS-1:0] msg, logic [hsec_pkg::CODE_BITS-1:0] rx);
			hsec_pkg::result_t e;
			int                s;
			e = '0;
			if (op == hsec_pkg::CMD_ENCODE) begin
				e.codeword = encode(msg);
			end else begin
				for (int b = 0; b < n_used; b++)
					e.codeword[b] = rx[b];
				s = syndrome(e.codeword);
				e.err_pos = hsec_pkg::SYN_BITS'(s);
				if (s > n_used)
					e.unc = 1'b1;
				else if (s != 0)
					e.codeword[s-1] = ~e.codeword[s-1];
			end
			e.message = data_bits(e.codeword);
			return e;
		endfunction

		function void note_request(hsec_pkg::cmd_t op,
			logic [hsec_pkg::MSG_BITS-1:0] msg, logic [hsec_pkg::CODE_BITS-1:0] rx);
			hsec_pkg::result_t e;
			e = predict(op, msg, rx);
			if (op == hsec_pkg::CMD_ENCODE)
				encodes++;
			else
				corrections++;
			if (e.unc)
				flagged++;
			awaited_results = {awaited_results, e};
		endfunction

		function void check_response(hsec_pkg::result_t got);
			hsec_pkg::result_t e;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: cw=%h msg=%h pos=%0d unc=%b",
						got.codeword, got.message, got.err_pos, got.unc);
				return;
			end
			e = awaited_results.pop_front();
			if (got.codeword !== e.codeword || got.message !== e.message ||
				got.err_pos !== e.err_pos || got.unc !== e.unc) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp cw=%h msg=%h pos=%0d unc=%b",
						e.codeword, e.message, e.err_pos, e.unc);
					$display("          got cw=%h msg=%h pos=%0d unc=%b",
						got.codeword, got.message, got.err_pos, got.unc);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   idle_pct;

	coder_scoreboard book;

	hsec_req_if req_ch();
	hsec_rsp_if rsp_ch();
	hsec_cfg_if cfg_ch();

	hamming_sec_encode_correct_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			book.check_response('{codeword: rsp_ch.codeword_out, message: rsp_ch.message_out,
				err_pos: rsp_ch.error_position, unc: rsp_ch.uncorrectable});
	end

	// Response back-pressure comes in bursts while idling is enabled.
	initial begin
		int hold;
		hold = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				rsp_ch.ready = 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				hold = $urandom_range(1, 14) - 1;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	task automatic send(hsec_pkg::cmd_t op, logic [hsec_pkg::MSG_BITS-1:0] msg,
		logic [hsec_pkg::CODE_BITS-1:0] rx);
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.cmd = op;
		req_ch.message_in = msg;
		req_ch.received_word = rx;
		do @(posedge clk); while (!req_ch.ready);
		book.note_request(op, msg, rx);
	endtask

	task automatic pause_requests();
		int gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 14);
			repeat (gap) begin
				@(negedge clk);
				req_ch.valid = 1'b0;
			end
		end
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (book.awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The length is only changed with no request in flight.
	task automatic write_length(logic [hsec_pkg::LEN_BITS-1:0] value);
		drain();
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.message_length = value;
		do @(posedge clk); while (!cfg_ch.ready);
		book.set_length(value);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Mostly valid codewords with zero, one or two flipped bits, plus encodes and raw noise.
	task automatic random_item();
		logic [hsec_pkg::CODE_BITS-1:0] raw;
		logic [hsec_pkg::CODE_BITS-1:0] word;
		int                             kind;
		int                             flips;
		raw = {$urandom, $urandom};
		kind = $urandom_range(0, 9);
		if (kind < 3) begin
			send(hsec_pkg::CMD_ENCODE, raw[hsec_pkg::MSG_BITS-1:0], {$urandom, $urandom});
		end else if (kind < 8) begin
			word = book.encode(raw[hsec_pkg::MSG_BITS-1:0]);
			flips = $urandom_range(0, 2);
			repeat (flips)
				word[$urandom_range(0, book.n_used - 1)] ^= 1'b1;
			if ($urandom_range(0, 3) == 0)
				word ^= {$urandom, $urandom} & ({hsec_pkg::CODE_BITS{1'b1}} << book.n_used);
			send(hsec_pkg::CMD_CORRECT, hsec_pkg::MSG_BITS'({$urandom, $urandom}), word);
		end else begin
			send(hsec_pkg::CMD_CORRECT, raw[hsec_pkg::MSG_BITS-1:0], {$urandom, $urandom});
		end
	endtask

	task automatic random_phase(logic [hsec_pkg::LEN_BITS-1:0] value, int count, int pct);
		write_length(value);
		idle_pct = pct;
		repeat (count) begin
			pause_requests();
			random_item();
		end
	endtask

	initial begin
		book = new();
		cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = hsec_pkg::CMD_ENCODE;
		req_ch.message_in = '0;
		req_ch.received_word = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.message_length = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset length of four: extremes of both fields and a single flipped bit.
		send(hsec_pkg::CMD_ENCODE, '0, '0);
		send(hsec_pkg::CMD_ENCODE, {hsec_pkg::MSG_BITS{1'b1}}, '0);
		send(hsec_pkg::CMD_CORRECT, '0, '0);
		send(hsec_pkg::CMD_CORRECT, {hsec_pkg::MSG_BITS{1'b1}}, {hsec_pkg::CODE_BITS{1'b1}});
		send(hsec_pkg::CMD_CORRECT, '0, book.encode(57'hB) ^ 64'h4);
		// With a nine-bit codeword, positions seven and eight give a syndrome past the end.
		write_length(6'd5);
		send(hsec_pkg::CMD_CORRECT, '0, 64'hC0);
		send(hsec_pkg::CMD_CORRECT, '0, {hsec_pkg::CODE_BITS{1'b1}});
		// A length of zero is taken as one.
		write_length(6'd0);
		send(hsec_pkg::CMD_ENCODE, {hsec_pkg::MSG_BITS{1'b1}}, '0);
		send(hsec_pkg::CMD_CORRECT, '0, {hsec_pkg::CODE_BITS{1'b1}} ^ 64'h2);
		// Lengths above the maximum are taken as the maximum.
		write_length(6'd63);
		send(hsec_pkg::CMD_ENCODE, {hsec_pkg::MSG_BITS{1'b1}}, '0);
		send(hsec_pkg::CMD_CORRECT, '0, {hsec_pkg::CODE_BITS{1'b1}});
		write_length(hsec_pkg::MSG_MAX);
		send(hsec_pkg::CMD_ENCODE, {hsec_pkg::MSG_BITS{1'b1}}, {hsec_pkg::CODE_BITS{1'b1}});
		send(hsec_pkg::CMD_CORRECT, '0,
			book.encode(57'h155_5555_5555_5555) ^ (64'd1 << 62));
		send(hsec_pkg::CMD_CORRECT, {hsec_pkg::MSG_BITS{1'b1}}, {hsec_pkg::CODE_BITS{1'b1}});
		write_length(6'd58);
		send(hsec_pkg::CMD_ENCODE, hsec_pkg::MSG_BITS'({$urandom, $urandom}),
			{$urandom, $urandom});

		random_phase(6'd1, 85, 20);
		random_phase(hsec_pkg::MSG_MAX, 85, 10);
		random_phase(6'd2, 85, 0);
		random_phase(6'd63, 85, 35);
		random_phase(6'd0, 85, 15);
		random_phase(6'd26, 85, 25);
		random_phase(hsec_pkg::LEN_BITS'($urandom_range(0, 63)), 85, 5);
		random_phase(hsec_pkg::LEN_BITS'($urandom_range(3, 30)), 85, 30);
		// Final stretch at full rate on both sides.
		random_phase(hsec_pkg::LEN_BITS'($urandom_range(0, 63)), 150, 0);

		drain();
		repeat (10) @(posedge clk);
		$display("Covered %0d encodes and %0d corrections over %0d length settings,",
			book.encodes, book.corrections, book.settings);
		$display("%0d of them flagged uncorrectable; %0d mismatches.",
			book.flagged, book.mismatches);
		if (book.mismatches == 0 && book.awaited_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
